// File: design/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared constants, types and functions
// Widths, the arctangent table and helpers used by the tilt angle pipeline.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned Iters    = 60;
  localparam int unsigned IterW    = 6;
  localparam int unsigned SqW      = 33;  // y*y + z*z fits in 32 bits; margin
  localparam int unsigned RootW    = 31;  // sqrt of a 62-bit value
  localparam int unsigned RightAng = 23040;
  localparam logic [29:0] Deg256Q16 = 30'd961263669;

  // Control and flags carried with one angle down the pipeline
  typedef struct packed {
    logic neg;      // numerator negative
    logic zero_den; // root sum zero
    logic zero_num; // numerator zero
    logic swapped;  // sides swapped, result is 90 minus angle
  } ang_flags_t;

  // atan(2^-i) in Q61 radians, power series with truncated terms
  function automatic logic signed [63:0] atan_pow2(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        e;
    sum = '0;
    for (int unsigned n = 0; n < 31; n++) begin
      e = i * (2 * n + 1);
      if (e <= 61) begin
        term = (64'd1 << (61 - e)) / 64'(2 * n + 1);
        if (n[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // Arithmetic right shift by a constant amount rounds toward minus infinity
  function automatic logic signed [63:0] sar(input logic signed [63:0] v,
                                             input int unsigned k);
    return v >>> k;
  endfunction

endpackage

// File: design/ata_angle.sv
// ----------------------------------------------------------------------------
// ata_angle: one tilt angle, atan(num / sqrt(a*a + b*b))
// Pipeline: squares, normalize, bit-serial square root as stages, side
// normalize, one CORDIC vectoring stage per iteration, scale and sign.
// ----------------------------------------------------------------------------
module ata_angle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [ata_pkg::SampleW-1:0] num_i,
  input  logic signed [ata_pkg::SampleW-1:0] a_i,
  input  logic signed [ata_pkg::SampleW-1:0] b_i,
  output logic                               valid_o,
  output logic signed [ata_pkg::AngleW-1:0]  angle_o
);
  import ata_pkg::*;

  localparam int unsigned RootSteps = 31;
  // Stages: 0 squares, 1 sum, 2 norm, 3..33 root, 34 side norm,
  // 35..94 cordic, 95 multiply, 96 round/sign
  localparam int unsigned NStages = 3 + RootSteps + 1 + Iters + 2;

  logic [NStages-1:0] v_q;

  // ---------------- stage 0: magnitudes and squares ----------------
  logic [31:0]        sqa_q, sqb_q;
  logic [SampleW-1:0] u0_q;
  logic               neg0_q;
  logic [SampleW-1:0] abs_a, abs_b, abs_n;

  always_comb begin
    abs_a = a_i[SampleW-1]   ? SampleW'(-a_i)   : SampleW'(a_i);
    abs_b = b_i[SampleW-1]   ? SampleW'(-b_i)   : SampleW'(b_i);
    abs_n = num_i[SampleW-1] ? SampleW'(-num_i) : SampleW'(num_i);
  end

  always_ff @(posedge clk_i) begin
    sqa_q  <= abs_a * abs_a;
    sqb_q  <= abs_b * abs_b;
    u0_q   <= abs_n;
    neg0_q <= num_i[SampleW-1];
  end

  // ---------------- stage 1: sum of squares ----------------
  logic [SqW-1:0]     s1_q;
  logic [SampleW-1:0] u1_q;
  logic               neg1_q;

  always_ff @(posedge clk_i) begin
    s1_q   <= SqW'(sqa_q) + SqW'(sqb_q);
    u1_q   <= u0_q;
    neg1_q <= neg0_q;
  end

  // ---------------- stage 2: normalize s to [2^60, 2^62) ----------------
  logic [63:0]        rs_q  [RootSteps+1];
  logic [RootW:0]     rr_q  [RootSteps+1];
  logic [4:0]         rm_q  [RootSteps+1];
  logic [SampleW-1:0] ru_q  [RootSteps+1];
  ang_flags_t         rf_q  [RootSteps+1];
  logic [4:0]         m_c;

  // k-th double shift is needed while s < 2^(62 - 2k)
  always_comb begin
    m_c = '0;
    for (int k = 1; k <= 30; k++) begin
      if (s1_q != '0 && 64'(s1_q) < (64'd1 << (62 - 2 * k)))
        m_c = 5'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q[0]          <= 64'(s1_q) << (2 * m_c);
    rr_q[0]          <= '0;
    rm_q[0]          <= m_c;
    ru_q[0]          <= u1_q;
    rf_q[0].neg      <= neg1_q;
    rf_q[0].zero_den <= (s1_q == '0);
    rf_q[0].zero_num <= (u1_q == '0);
    rf_q[0].swapped  <= 1'b0;
  end

  // ---------------- root stages: one result bit per stage ----------------
  for (genvar g = 0; g < RootSteps; g++) begin : g_root
    localparam int unsigned Sh = 2 * (RootSteps - 1 - g);
    logic [63:0]    trial;
    logic [RootW:0] rnext;
    always_comb begin
      trial = (64'(rr_q[g]) << 2 | 64'd1) << Sh;
      rnext = rr_q[g] << 1;
      if (rs_q[g] >= ((64'(rr_q[g]) << (Sh + 2)) | (64'd1 << Sh)) ) begin
        rnext = (rr_q[g] << 1) | 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      rr_q[g+1] <= rnext;
      rs_q[g+1] <= (rnext[0]) ? rs_q[g] - trial : rs_q[g];
      rm_q[g+1] <= rm_q[g];
      ru_q[g+1] <= ru_q[g];
      rf_q[g+1] <= rf_q[g];
    end
  end

  // ---------------- side normalize and swap ----------------
  logic [63:0] d_c, opp_c, p_c, q_c, big_c;
  logic        sw_c;
  logic [5:0]  sh_c;
  ang_flags_t  fsw_c;

  logic signed [63:0] cp_q [Iters+1];
  logic signed [63:0] cq_q [Iters+1];
  logic signed [63:0] cz_q [Iters+1];
  ang_flags_t         cf_q [Iters+1];

  // k-th shift is needed while big < 2^(59 - k)
  always_comb begin
    d_c   = 64'(rr_q[RootSteps]);
    opp_c = 64'(ru_q[RootSteps]) << rm_q[RootSteps];
    sw_c  = opp_c > d_c;
    big_c = sw_c ? opp_c : d_c;
    sh_c  = '0;
    for (int k = 1; k < 59; k++) begin
      if (big_c < (64'd1 << (59 - k))) sh_c = 6'(k);
    end
    if (big_c == '0) sh_c = '0;
    p_c = (sw_c ? opp_c : d_c) << sh_c;
    q_c = (sw_c ? d_c : opp_c) << sh_c;
    fsw_c         = rf_q[RootSteps];
    fsw_c.swapped = sw_c;
  end

  always_ff @(posedge clk_i) begin
    cp_q[0] <= $signed(p_c);
    cq_q[0] <= $signed(q_c);
    cz_q[0] <= '0;
    cf_q[0] <= fsw_c;
  end

  // ---------------- CORDIC stages ----------------
  for (genvar g = 0; g < Iters; g++) begin : g_cordic
    localparam int unsigned Sh = g + 1;
    localparam logic signed [63:0] AtanK = atan_pow2(g + 1);
    always_ff @(posedge clk_i) begin
      if (!cq_q[g][63]) begin
        cp_q[g+1] <= cp_q[g] + sar(cq_q[g], Sh);
        cq_q[g+1] <= cq_q[g] - sar(cp_q[g], Sh);
        cz_q[g+1] <= cz_q[g] + AtanK;
      end else begin
        cp_q[g+1] <= cp_q[g] - sar(cq_q[g], Sh);
        cq_q[g+1] <= cq_q[g] + sar(cp_q[g], Sh);
        cz_q[g+1] <= cz_q[g] - AtanK;
      end
      cf_q[g+1] <= cf_q[g];
    end
  end

  // ---------------- scale to 1/256 degree ----------------
  logic [31:0] r32_c;
  logic [63:0] prod_q;
  ang_flags_t  fm_q;

  always_comb begin
    r32_c = cz_q[Iters][63] ? '0 : 32'(cz_q[Iters] >>> 29);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= r32_c * Deg256Q16;
    fm_q   <= cf_q[Iters];
  end

  // ---------------- round, fold and sign ----------------
  logic [63:0]               rnd_c;
  logic signed [AngleW:0]    ang_c;
  logic signed [AngleW-1:0]  ang_q;

  always_comb begin
    rnd_c = (prod_q + (64'd1 << 47)) >> 48;
    ang_c = (AngleW + 1)'(rnd_c);
    if (fm_q.swapped) ang_c = (AngleW + 1)'(RightAng) - ang_c;
    if (fm_q.neg) ang_c = -ang_c;
    if (fm_q.zero_den) begin
      ang_c = fm_q.zero_num ? '0 :
              (fm_q.neg ? -(AngleW + 1)'(RightAng) : (AngleW + 1)'(RightAng));
    end else if (fm_q.zero_num) begin
      ang_c = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= AngleW'(ang_c);
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NStages-2:0], valid_i};
    end
  end

  assign valid_o = v_q[NStages-1];
  assign angle_o = ang_q;

endmodule

// File: design/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles: pitch and roll from a three-axis accelerometer sample
// Two identical angle pipelines, one per output angle.
// ----------------------------------------------------------------------------
// Usage: drive axis_x_i/axis_y_i/axis_z_i and raise start; the item is
// taken on any edge where start is high (busy is always low, the
// pipeline accepts an item every cycle). Each item produces one result:
// pitch_deg_o and roll_deg_o are valid for exactly one cycle while
// done_o is high; that cycle comes once the item has passed every stage
// of both angle pipelines, ending with round and sign. Throughput is one
// item per cycle; the 31-stage square root and the 60-stage CORDIC chain
// make up most of the pipeline. Results leave in the order items entered.
// Reset clears the valid chain only, so no stray done_o appears; data
// registers are not reset. The receiver cannot stall, so no result is held.
// ----------------------------------------------------------------------------
module accel_tilt_angles (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ata_pkg::SampleW-1:0] axis_x_i,
  input  logic signed [ata_pkg::SampleW-1:0] axis_y_i,
  input  logic signed [ata_pkg::SampleW-1:0] axis_z_i,
  output logic                               done_o,
  output logic signed [ata_pkg::AngleW-1:0]  pitch_deg_o,
  output logic signed [ata_pkg::AngleW-1:0]  roll_deg_o
);
  import ata_pkg::*;

  logic valid_p, valid_r;

  assign busy = 1'b0;

  // pitch: atan(x / sqrt(y^2 + z^2))
  ata_angle u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .num_i   (axis_x_i),
    .a_i     (axis_y_i),
    .b_i     (axis_z_i),
    .valid_o (valid_p),
    .angle_o (pitch_deg_o)
  );

  // roll: atan(y / sqrt(x^2 + z^2))
  ata_angle u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .num_i   (axis_y_i),
    .a_i     (axis_x_i),
    .b_i     (axis_z_i),
    .valid_o (valid_r),
    .angle_o (roll_deg_o)
  );

  assign done_o = valid_p & valid_r;

endmodule
